[rtl/core/mspt_pkg.sv]
// mspt_pkg: shared widths, request and result codes and the result word type
// for the sustain pedal note tracker core and its port checker
// depends on nothing
`default_nettype none

package mspt_pkg;

   // field widths fixed by the event format
   localparam int TYPE_W = 2;
   localparam int NOTE_W = 7;
   localparam int VEL_W  = 7;
   localparam int KIND_W = 2;
   localparam int MASK_W = 64;

   // full MIDI note range, two mask halves
   localparam int MAX_NOTES          = 128;
   localparam int NOTE_COUNT_DEFAULT = 128;

   // depth of the result queue in front of the rsp channel
   localparam int RSP_DEPTH = 4;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_NOTE_ON  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_NOTE_OFF = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SUSTAIN  = 2'd2;

   // result codes
   localparam logic [KIND_W-1:0] RSP_NOTE_ON    = 2'd0;
   localparam logic [KIND_W-1:0] RSP_NOTE_OFF   = 2'd1;
   localparam logic [KIND_W-1:0] RSP_GROUP_OFF  = 2'd2;
   localparam logic [KIND_W-1:0] RSP_KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  velocity;
      logic              half;
      logic [MASK_W-1:0] mask;
      logic              last;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/core/midi_sustain_pedal_tracker_core.sv]
// midi_sustain_pedal_tracker_core: top level of the sustain pedal note tracker
// depends on mspt_pkg
`default_nettype none

// Takes decoded MIDI words (note on, note off, sustain controller) on the req
// channel and sends note on, note off and group note off words to a synth on
// the rsp channel, holding notes while the sustain pedal is down. A note on
// with velocity 0 is a note off; a sustained note struck again is stopped and
// restarted at the higher of its two velocities; pedal changes release notes
// as 64-bit masks, one word per non-empty half. Each req word gives zero, one
// or two rsp words, the final one flagged by rsp_last. A req word goes into an
// input register (the stored velocity of its note is read from the velocity
// memory in the same cycle), waits there until the result queue has room for
// all its results, is processed in one pass over the per-note bitmaps, and
// its rsp words land in a 4-entry result queue. Words that give at most one
// rsp word are taken one per cycle while the queue has room; a word with two
// rsp words takes two queue entries, so the rate is set by the rsp side and
// its queue. All state is ready right after reset, no clearing pass.

module midi_sustain_pedal_tracker_core #(
   parameter int NOTE_COUNT = mspt_pkg::NOTE_COUNT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mspt_pkg::TYPE_W-1:0]  req_type,
   input  logic [mspt_pkg::NOTE_W-1:0]  req_note,
   input  logic [mspt_pkg::VEL_W-1:0]   req_value,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mspt_pkg::KIND_W-1:0]  rsp_kind,
   output logic [mspt_pkg::NOTE_W-1:0]  rsp_out_note,
   output logic [mspt_pkg::VEL_W-1:0]   rsp_out_velocity,
   output logic                         rsp_group_half,
   output logic [mspt_pkg::MASK_W-1:0]  rsp_release_mask,
   output logic                         rsp_last
);

   import mspt_pkg::*;

   localparam int NIDX_W = $clog2(NOTE_COUNT);
   localparam int PTR_W  = $clog2(RSP_DEPTH);
   localparam int CNT_W  = $clog2(RSP_DEPTH + 1);

   // result word builders
   function automatic rsp_word_type single_word(input logic [KIND_W-1:0] kind,
                                                input logic [NOTE_W-1:0] note,
                                                input logic [VEL_W-1:0]  vel);
      rsp_word_type w;
      w          = '0;
      w.kind     = kind;
      w.note     = note;
      w.velocity = vel;
      return w;
   endfunction

   function automatic rsp_word_type group_word(input logic              half,
                                               input logic [MASK_W-1:0] mask);
      rsp_word_type w;
      w      = '0;
      w.kind = RSP_GROUP_OFF;
      w.half = half;
      w.mask = mask;
      return w;
   endfunction

   // handshakes
   logic req_fire;
   logic rsp_fire;
   logic item_fire;
   logic fits;

   // input register, with the velocity memory read data alongside
   logic              item_valid_ff, item_valid_in;
   logic [TYPE_W-1:0] item_type_ff;
   logic [NOTE_W-1:0] item_note_ff;
   logic [VEL_W-1:0]  item_value_ff;
   logic [VEL_W-1:0]  item_mem_vel_ff;

   // per-note state
   logic [NOTE_COUNT-1:0] key_down_ff, key_down_in;
   logic [NOTE_COUNT-1:0] by_key_ff, by_key_in;
   logic [NOTE_COUNT-1:0] by_pedal_ff, by_pedal_in;
   logic                  pedal_down_ff, pedal_down_in;
   logic [VEL_W-1:0]      vel_mem [NOTE_COUNT];

   // processing stage
   logic [NIDX_W-1:0]    n_idx;
   logic [NIDX_W-1:0]    rd_idx;
   logic                 in_range;
   logic                 rd_in_range;
   logic [VEL_W-1:0]     hi_vel;
   logic [MAX_NOTES-1:0] rel_wide;
   logic [MASK_W-1:0]    rel_lo;
   logic [MASK_W-1:0]    rel_hi;
   logic [1:0]           res_cnt;
   rsp_word_type         res0;
   rsp_word_type         res1;
   logic                 vel_wr_en;
   logic [VEL_W-1:0]     vel_wr_data;

   // result queue
   rsp_word_type     fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_word_type     head;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // the held word goes ahead only when the queue has room for all its results
   assign fits = ((CNT_W+1)'(count_ff) + (CNT_W+1)'(res_cnt)) <= (CNT_W+1)'(RSP_DEPTH);
   assign item_fire = item_valid_ff && fits;
   assign req_ready = !item_valid_ff || item_fire;

   // note index and range checks, stage and memory read side
   assign n_idx       = item_note_ff[NIDX_W-1:0];
   assign rd_idx      = req_note[NIDX_W-1:0];
   assign in_range    = {1'b0, item_note_ff} < (NOTE_W+1)'(NOTE_COUNT);
   assign rd_in_range = {1'b0, req_note} < (NOTE_W+1)'(NOTE_COUNT);

   // restart velocity of a retriggered sustained note
   assign hi_vel = (item_mem_vel_ff > item_value_ff) ? item_mem_vel_ff : item_value_ff;

   // ---------------------------------------------------------------- input register
   assign item_valid_in = req_fire ? 1'b1 : (item_fire ? 1'b0 : item_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_type_ff  <= req_type;
         item_note_ff  <= req_note;
         item_value_ff <= req_value;
      end
   end

   // ---------------------------------------------------------------- velocity memory
   // write from the processing stage, read for the incoming word; a write to the
   // same note in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (item_fire && vel_wr_en) begin
         vel_mem[n_idx] <= vel_wr_data;
      end
      if (req_fire) begin
         if (item_fire && vel_wr_en && (rd_idx == n_idx)) begin
            item_mem_vel_ff <= vel_wr_data;
         end else if (rd_in_range) begin
            item_mem_vel_ff <= vel_mem[rd_idx];
         end
      end
   end

   // ---------------------------------------------------------------- processing
   always_comb begin
      key_down_in   = key_down_ff;
      by_key_in     = by_key_ff;
      by_pedal_in   = by_pedal_ff;
      pedal_down_in = pedal_down_ff;
      rel_wide      = '0;
      res_cnt       = 2'd0;
      res0          = '0;
      res1          = '0;
      vel_wr_en     = 1'b0;
      vel_wr_data   = item_value_ff;

      case (item_type_ff) inside
         REQ_SUSTAIN: begin
            if (item_value_ff != '0) begin
               // pedal down: flush whatever the pedal still holds, then take over
               // the notes sounding by key
               rel_wide      = MAX_NOTES'(by_pedal_ff);
               by_pedal_in   = by_key_ff;
               by_key_in     = '0;
               pedal_down_in = 1'b1;
            end else begin
               // pedal up: release unheld notes, hand held ones back to the keys
               rel_wide      = MAX_NOTES'(by_pedal_ff & ~key_down_ff);
               by_key_in     = by_key_ff | (by_pedal_ff & key_down_ff);
               by_pedal_in   = '0;
               pedal_down_in = 1'b0;
            end
         end
         REQ_NOTE_ON, REQ_NOTE_OFF: begin
            if (in_range) begin
               if ((item_type_ff == REQ_NOTE_ON) && (item_value_ff != '0)) begin
                  key_down_in[n_idx] = 1'b1;
                  vel_wr_en          = 1'b1;
                  if (pedal_down_ff) begin
                     // retrigger under the pedal: stop, restart at the louder velocity
                     if (by_pedal_ff[n_idx]) begin
                        res0        = single_word(RSP_NOTE_OFF, item_note_ff, '0);
                        res1        = single_word(RSP_NOTE_ON, item_note_ff, hi_vel);
                        res_cnt     = 2'd2;
                        vel_wr_data = hi_vel;
                     end else begin
                        res0    = single_word(RSP_NOTE_ON, item_note_ff, item_value_ff);
                        res_cnt = 2'd1;
                     end
                     by_pedal_in[n_idx] = 1'b1;
                  end else begin
                     if (by_key_ff[n_idx]) begin
                        res0    = single_word(RSP_NOTE_OFF, item_note_ff, '0);
                        res1    = single_word(RSP_NOTE_ON, item_note_ff, item_value_ff);
                        res_cnt = 2'd2;
                     end else begin
                        res0    = single_word(RSP_NOTE_ON, item_note_ff, item_value_ff);
                        res_cnt = 2'd1;
                     end
                     by_key_in[n_idx] = 1'b1;
                  end
               end else begin
                  // note off, or note on at velocity zero
                  key_down_in[n_idx] = 1'b0;
                  if (by_key_ff[n_idx]) begin
                     res0             = single_word(RSP_NOTE_OFF, item_note_ff, '0);
                     res_cnt          = 2'd1;
                     by_key_in[n_idx] = 1'b0;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // group release words, one per non-empty half, low half first
      if (item_type_ff == REQ_SUSTAIN) begin
         if (rel_lo != '0) begin
            res0 = group_word(1'b0, rel_lo);
            if (rel_hi != '0) begin
               res1    = group_word(1'b1, rel_hi);
               res_cnt = 2'd2;
            end else begin
               res_cnt = 2'd1;
            end
         end else if (rel_hi != '0) begin
            res0    = group_word(1'b1, rel_hi);
            res_cnt = 2'd1;
         end
      end

      res0.last = (res_cnt == 2'd1);
      res1.last = 1'b1;
   end

   assign rel_lo = rel_wide[MASK_W-1:0];
   assign rel_hi = rel_wide[MAX_NOTES-1:MASK_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_down_ff   <= '0;
         by_key_ff     <= '0;
         by_pedal_ff   <= '0;
         pedal_down_ff <= 1'b0;
      end else if (item_fire) begin
         key_down_ff   <= key_down_in;
         by_key_ff     <= by_key_in;
         by_pedal_ff   <= by_pedal_in;
         pedal_down_ff <= pedal_down_in;
      end
   end

   // ---------------------------------------------------------------- result queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (item_fire) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(res_cnt);
         count_in  = count_in + CNT_W'(res_cnt);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire && (res_cnt != 2'd0)) begin
         fifo_ff[wr_ptr_ff] <= res0;
         if (res_cnt == 2'd2) begin
            fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
         end
      end
   end

   assign head             = fifo_ff[rd_ptr_ff];
   assign rsp_valid        = (count_ff != '0);
   assign rsp_kind         = head.kind;
   assign rsp_out_note     = head.note;
   assign rsp_out_velocity = head.velocity;
   assign rsp_group_half   = head.half;
   assign rsp_release_mask = head.mask;
   assign rsp_last         = head.last;

endmodule

`default_nettype wire

[rtl/core/mspt_checker.sv]
// mspt_checker: port-level assertions for the sustain pedal note tracker core,
// bound to the top level at the end of this file
// depends on mspt_pkg and midi_sustain_pedal_tracker_core
`default_nettype none

module mspt_checker #(
   parameter int NOTE_COUNT = mspt_pkg::NOTE_COUNT_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mspt_pkg::KIND_W-1:0]  rsp_kind,
   input logic [mspt_pkg::NOTE_W-1:0]  rsp_out_note,
   input logic [mspt_pkg::VEL_W-1:0]   rsp_out_velocity,
   input logic                         rsp_group_half,
   input logic [mspt_pkg::MASK_W-1:0]  rsp_release_mask,
   input logic                         rsp_last
);

   import mspt_pkg::*;

   // a stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_note)
         && $stable(rsp_out_velocity) && $stable(rsp_group_half)
         && $stable(rsp_release_mask) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // group words carry a nonempty mask and no note or velocity
   a_group_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == RSP_GROUP_OFF) |->
         (rsp_release_mask != '0) && (rsp_out_note == '0) && (rsp_out_velocity == '0))
      else $error("malformed group release word");

   // single words name a tracked note and carry no mask
   a_single_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == RSP_NOTE_ON) || (rsp_kind == RSP_NOTE_OFF)) |->
         (rsp_release_mask == '0) && !rsp_group_half
         && ({1'b0, rsp_out_note} < (NOTE_W+1)'(NOTE_COUNT)))
      else $error("malformed single note word");

   // note on goes out at a nonzero velocity, every other kind at zero; the unused kind never appears
   a_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != RSP_KIND_UNUSED)
         && ((rsp_kind == RSP_NOTE_ON) == (rsp_out_velocity != '0)))
      else $error("bad velocity or kind on rsp word");

endmodule

bind midi_sustain_pedal_tracker_core mspt_checker #(
   .NOTE_COUNT (NOTE_COUNT)
) u_mspt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_out_note     (rsp_out_note),
   .rsp_out_velocity (rsp_out_velocity),
   .rsp_group_half   (rsp_group_half),
   .rsp_release_mask (rsp_release_mask),
   .rsp_last         (rsp_last)
);

`default_nettype wire

[dv/testbench.sv]
// testbench: self-checking bench for midi_sustain_pedal_tracker_core, driving MIDI words
// from a directed table and then at random, and comparing rsp words against a local model
// depends on mspt_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;
   import mspt_pkg::*;

   localparam int NOTES        = NOTE_COUNT_DEFAULT;
   localparam int PLAN_ROWS    = 25;
   localparam int RANDOM_WORDS = 1030;
   localparam int HOLD_AT      = 350;   // long rsp hold-off starts here
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 700;   // sender drains all rsp words here
   localparam int TAIL_CYCLES  = 8;     // margin for the input register plus the result queue

   // the one request code the package leaves unnamed, ignored by the core
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam rsp_word_type NO_WORD = '0;

   typedef struct {
      logic [TYPE_W-1:0] op;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  value;
      bit                typed;   // expected words written in the row
      int                count;
      rsp_word_type      first;
      rsp_word_type      second;
   } plan_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TYPE_W-1:0] req_type  = '0;
   logic [NOTE_W-1:0] req_note  = '0;
   logic [VEL_W-1:0]  req_value = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [NOTE_W-1:0] rsp_out_note;
   logic [VEL_W-1:0]  rsp_out_velocity;
   logic              rsp_group_half;
   logic [MASK_W-1:0] rsp_release_mask;
   logic              rsp_last;

   // model state of the tracker
   logic [MAX_NOTES-1:0] held_keys    = '0;
   logic [MAX_NOTES-1:0] key_voices   = '0;
   logic [MAX_NOTES-1:0] pedal_voices = '0;
   logic [VEL_W-1:0]     voice_velocity [MAX_NOTES];
   logic                 pedal_is_down = 1'b0;

   rsp_word_type  expected_words [$];
   plan_row       plan [PLAN_ROWS];
   logic [NOTE_W-1:0] note_pool [8];

   int  mismatches   = 0;
   int  words_sent   = 0;
   int  ons_seen     = 0;
   int  offs_seen    = 0;
   int  groups_seen  = 0;
   bit  hold_request = 1'b0;
   bit  hold_done    = 1'b0;

   midi_sustain_pedal_tracker_core #(
      .NOTE_COUNT (NOTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_note         (req_note),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_note     (rsp_out_note),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_group_half   (rsp_group_half),
      .rsp_release_mask (rsp_release_mask),
      .rsp_last         (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   function automatic rsp_word_type word_of(input logic [KIND_W-1:0] kind,
                                            input logic [NOTE_W-1:0] note,
                                            input logic [VEL_W-1:0]  vel,
                                            input logic              half,
                                            input logic [MASK_W-1:0] mask,
                                            input logic              last);
      rsp_word_type w;
      w.kind     = kind;
      w.note     = note;
      w.velocity = vel;
      w.half     = half;
      w.mask     = mask;
      w.last     = last;
      return w;
   endfunction

   // advance the tracker model by one req word; keep=0 drops the predicted words
   task automatic track_event(input logic [TYPE_W-1:0] op, input logic [NOTE_W-1:0] n,
                              input logic [VEL_W-1:0] v, input bit keep);
      rsp_word_type         caused [$];
      rsp_word_type         w;
      logic [MASK_W-1:0]    part;
      logic [MAX_NOTES-1:0] freed;
      logic [VEL_W-1:0]     vel;
      if (op == REQ_SUSTAIN) begin
         if (v != '0) begin
            // pedal down: anything still held by the pedal goes, key voices move over
            for (int h = 0; h < 2; h++) begin
               part = pedal_voices[h*MASK_W +: MASK_W];
               if (part != '0)
                  caused.push_back(word_of(RSP_GROUP_OFF, '0, '0, 1'(h), part, 1'b0));
            end
            pedal_voices  = key_voices;
            key_voices    = '0;
            pedal_is_down = 1'b1;
         end else begin
            // pedal up: free voices whose key is up, keep the held ones by key
            freed = pedal_voices & ~held_keys;
            for (int h = 0; h < 2; h++) begin
               part = freed[h*MASK_W +: MASK_W];
               if (part != '0)
                  caused.push_back(word_of(RSP_GROUP_OFF, '0, '0, 1'(h), part, 1'b0));
            end
            key_voices    = key_voices | (pedal_voices & held_keys);
            pedal_voices  = '0;
            pedal_is_down = 1'b0;
         end
      end else if ((op == REQ_NOTE_ON || op == REQ_NOTE_OFF) && int'(n) < NOTES) begin
         if (op == REQ_NOTE_ON && v != '0) begin
            vel          = v;
            held_keys[n] = 1'b1;
            if (pedal_is_down) begin
               if (pedal_voices[n]) begin
                  caused.push_back(word_of(RSP_NOTE_OFF, n, '0, 1'b0, '0, 1'b0));
                  if (voice_velocity[n] > vel)
                     vel = voice_velocity[n];
               end
               pedal_voices[n] = 1'b1;
            end else begin
               if (key_voices[n])
                  caused.push_back(word_of(RSP_NOTE_OFF, n, '0, 1'b0, '0, 1'b0));
               key_voices[n] = 1'b1;
            end
            voice_velocity[n] = vel;
            caused.push_back(word_of(RSP_NOTE_ON, n, vel, 1'b0, '0, 1'b0));
         end else begin
            // note off, or note on at velocity zero
            held_keys[n] = 1'b0;
            if (key_voices[n]) begin
               caused.push_back(word_of(RSP_NOTE_OFF, n, '0, 1'b0, '0, 1'b0));
               key_voices[n] = 1'b0;
            end
         end
      end
      if (caused.size() != 0) begin
         w      = caused.pop_back();
         w.last = 1'b1;
         caused.push_back(w);
      end
      if (keep)
         foreach (caused[k])
            expected_words.push_back(caused[k]);
   endtask

   // present one req word after an optional gap or drain, return once accepted
   task automatic offer_word(input logic [TYPE_W-1:0] op, input logic [NOTE_W-1:0] n,
                             input logic [VEL_W-1:0] v, input int gap, input bit drain);
      if (gap > 0 || drain) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         while (drain && expected_words.size() != 0)
            @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type  <= op;
      req_note  <= n;
      req_value <= v;
      do
         @(posedge clock);
      while (!req_ready);
      words_sent++;
   endtask

   // mostly a small pool of notes so retriggers and pedal moves pile up
   task automatic pick_event(output logic [TYPE_W-1:0] op, output logic [NOTE_W-1:0] n,
                             output logic [VEL_W-1:0] v);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         op = REQ_NOTE_ON;
      else if (roll < 75)
         op = REQ_NOTE_OFF;
      else if (roll < 94)
         op = REQ_SUSTAIN;
      else
         op = REQ_UNUSED;
      if ($urandom_range(0, 9) < 7)
         n = note_pool[$urandom_range(0, 7)];
      else
         n = NOTE_W'($urandom_range(0, 127));
      case (op)
         REQ_NOTE_ON: begin
            v = ($urandom_range(0, 9) == 0) ? '0 : VEL_W'($urandom_range(1, 127));
         end
         REQ_SUSTAIN: begin
            v = ($urandom_range(0, 1) == 0) ? '0 : VEL_W'($urandom_range(1, 127));
         end
         default: begin
            v = VEL_W'($urandom_range(0, 127));
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [MASK_W-1:0] want,
                                input logic [MASK_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // rsp side: every accepted word against the oldest expectation
   always @(posedge clock) begin : watch_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("rsp word with nothing expected: kind %0d note %0d", rsp_kind,
                   rsp_out_note);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            compare_field("rsp_kind", MASK_W'(want.kind), MASK_W'(rsp_kind));
            compare_field("rsp_out_note", MASK_W'(want.note), MASK_W'(rsp_out_note));
            compare_field("rsp_out_velocity", MASK_W'(want.velocity),
                          MASK_W'(rsp_out_velocity));
            compare_field("rsp_group_half", MASK_W'(want.half), MASK_W'(rsp_group_half));
            compare_field("rsp_release_mask", want.mask, rsp_release_mask);
            compare_field("rsp_last", MASK_W'(want.last), MASK_W'(rsp_last));
         end
         case (rsp_kind)
            RSP_NOTE_ON:   ons_seen++;
            RSP_NOTE_OFF:  offs_seen++;
            default:       groups_seen++;
         endcase
      end
   end

   // rsp ready: stretches of always ready, random stalls, a fixed pattern,
   // and one long hold-off on request so the core backs up into req
   initial begin : drive_rsp_ready
      int mode;
      int stretch;
      int tick;
      mode    = 0;
      stretch = 0;
      tick    = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (stretch == 0) begin
               mode    = $urandom_range(0, 3);
               stretch = $urandom_range(10, 80);
            end
            stretch--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   initial begin : run_stimulus
      logic [TYPE_W-1:0] op;
      logic [NOTE_W-1:0] n;
      logic [VEL_W-1:0]  v;
      int  counted;
      int  burst_left;
      int  gap;
      bit  drain;
      bit  paused;

      foreach (voice_velocity[k])
         voice_velocity[k] = '0;

      // directed rows; typed ones are read straight off the behavior
      plan[0]  = '{REQ_NOTE_ON, 7'd0, 7'd127, 1'b1, 1,
                   word_of(RSP_NOTE_ON, 7'd0, 7'd127, 1'b0, '0, 1'b1), NO_WORD};
      plan[1]  = '{REQ_NOTE_ON, 7'd127, 7'd1, 1'b1, 1,
                   word_of(RSP_NOTE_ON, 7'd127, 7'd1, 1'b0, '0, 1'b1), NO_WORD};
      // retrigger of a key voice: off then on at the new velocity
      plan[2]  = '{REQ_NOTE_ON, 7'd0, 7'd5, 1'b1, 2,
                   word_of(RSP_NOTE_OFF, 7'd0, 7'd0, 1'b0, '0, 1'b0),
                   word_of(RSP_NOTE_ON, 7'd0, 7'd5, 1'b0, '0, 1'b1)};
      plan[3]  = '{REQ_NOTE_OFF, 7'd127, 7'd0, 1'b1, 1,
                   word_of(RSP_NOTE_OFF, 7'd127, 7'd0, 1'b0, '0, 1'b1), NO_WORD};
      // velocity zero on a silent note: nothing
      plan[4]  = '{REQ_NOTE_ON, 7'd64, 7'd0, 1'b1, 0, NO_WORD, NO_WORD};
      // unused request code: nothing
      plan[5]  = '{REQ_UNUSED, 7'd127, 7'd127, 1'b1, 0, NO_WORD, NO_WORD};
      plan[6]  = '{REQ_NOTE_ON, 7'd64, 7'd100, 1'b0, 0, NO_WORD, NO_WORD};
      // first pedal down with an empty pedal set, note field ignored
      plan[7]  = '{REQ_SUSTAIN, 7'd99, 7'd127, 1'b0, 0, NO_WORD, NO_WORD};
      plan[8]  = '{REQ_NOTE_OFF, 7'd0, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      // restrike of a sustained note keeps the higher velocity
      plan[9]  = '{REQ_NOTE_ON, 7'd64, 7'd50, 1'b0, 0, NO_WORD, NO_WORD};
      plan[10] = '{REQ_NOTE_ON, 7'd10, 7'd20, 1'b0, 0, NO_WORD, NO_WORD};
      plan[11] = '{REQ_NOTE_OFF, 7'd64, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      // repeated pedal down releases both halves by note number
      plan[12] = '{REQ_SUSTAIN, 7'd0, 7'd1, 1'b0, 0, NO_WORD, NO_WORD};
      plan[13] = '{REQ_NOTE_ON, 7'd127, 7'd127, 1'b0, 0, NO_WORD, NO_WORD};
      plan[14] = '{REQ_NOTE_ON, 7'd63, 7'd1, 1'b0, 0, NO_WORD, NO_WORD};
      plan[15] = '{REQ_NOTE_OFF, 7'd63, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      // pedal up: released key goes, held key moves back to key voices
      plan[16] = '{REQ_SUSTAIN, 7'd0, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      plan[17] = '{REQ_SUSTAIN, 7'd0, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      plan[18] = '{REQ_NOTE_OFF, 7'd127, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      plan[19] = '{REQ_NOTE_ON, 7'd1, 7'd127, 1'b0, 0, NO_WORD, NO_WORD};
      plan[20] = '{REQ_SUSTAIN, 7'd127, 7'd64, 1'b0, 0, NO_WORD, NO_WORD};
      plan[21] = '{REQ_NOTE_OFF, 7'd1, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      plan[22] = '{REQ_NOTE_ON, 7'd100, 7'd3, 1'b0, 0, NO_WORD, NO_WORD};
      plan[23] = '{REQ_NOTE_OFF, 7'd100, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};
      // pedal up with a release in each half
      plan[24] = '{REQ_SUSTAIN, 7'd0, 7'd0, 1'b0, 0, NO_WORD, NO_WORD};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         offer_word(plan[i].op, plan[i].note, plan[i].value, $urandom_range(0, 3), 1'b0);
         track_event(plan[i].op, plan[i].note, plan[i].value, !plan[i].typed);
         if (plan[i].typed && plan[i].count > 0)
            expected_words.push_back(plan[i].first);
         if (plan[i].typed && plan[i].count > 1)
            expected_words.push_back(plan[i].second);
      end

      foreach (note_pool[k])
         note_pool[k] = NOTE_W'($urandom_range(0, 127));

      counted    = 0;
      burst_left = 0;
      paused     = 1'b0;
      while (counted < RANDOM_WORDS) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            gap = 0;
         end
         burst_left--;
         // keep offering while the rsp side is held off
         if (hold_request && !hold_done)
            gap = 0;
         drain = (counted == PAUSE_AT && !paused);
         pick_event(op, n, v);
         offer_word(op, n, v, gap, drain);
         if (drain)
            paused = 1'b1;
         track_event(op, n, v, 1'b1);
         counted++;
         if (counted == HOLD_AT)
            hold_request = 1'b1;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d req words (%0d from the directed table), %0d rsp words",
               words_sent, PLAN_ROWS, ons_seen + offs_seen + groups_seen);
      $display("rsp words by kind: %0d note on, %0d note off, %0d group release",
               ons_seen, offs_seen, groups_seen);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/mspt_pkg.sv
rtl/core/midi_sustain_pedal_tracker_core.sv
rtl/core/mspt_checker.sv
dv/testbench.sv
